### src/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared widths, constants and types of the step spike detector.
// ----------------------------------------------------------------------------
package ssd_pkg;

    // window depths
    localparam int AXIS_WINDOW = 6;
    localparam int MAG_WINDOW  = 16;

    // field widths
    localparam int ACCEL_W    = 13;
    localparam int MAG_W      = 13;
    localparam int THR_W      = 13;
    localparam int CD_W       = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam int AXES       = 3;
    localparam int AXIS_IDX_W = 2;
    localparam int ABS_MAX    = 4096;
    localparam int MAG_MAX    = 7094;

    // running sums and write positions
    localparam int SUM_W  = $clog2(AXIS_WINDOW * ABS_MAX + 1);
    localparam int APOS_W = (AXIS_WINDOW > 1) ? $clog2(AXIS_WINDOW) : 1;
    localparam int MSUM_W = $clog2(MAG_WINDOW * MAG_MAX + 1);
    localparam int MPOS_W = (MAG_WINDOW > 1) ? $clog2(MAG_WINDOW) : 1;

    // reciprocals for the truncating means
    localparam int K_A     = SUM_W + $clog2(AXIS_WINDOW) + 1;
    localparam int RECIP_A = ((2 ** K_A) + AXIS_WINDOW - 1) / AXIS_WINDOW;
    localparam int RA_W    = K_A + 1;
    localparam int K_M     = MSUM_W + $clog2(MAG_WINDOW) + 1;
    localparam int RECIP_M = ((2 ** K_M) + MAG_WINDOW - 1) / MAG_WINDOW;
    localparam int RM_W    = K_M + 1;

    // sum of squares and root
    localparam int SQ_W   = 26;
    localparam int ROOT_W = SQ_W / 2;
    localparam int RCNT_W = $clog2(ROOT_W + 1);

    // shared multiplier
    localparam int MA_W0 = (SUM_W > MSUM_W) ? SUM_W : MSUM_W;
    localparam int MA_W  = (MA_W0 > MAG_W) ? MA_W0 : MAG_W;
    localparam int MB_W0 = (RA_W > RM_W) ? RA_W : RM_W;
    localparam int MB_W  = (MB_W0 > MAG_W) ? MB_W0 : MAG_W;
    localparam int P_W   = MA_W + MB_W;

    // register reset values
    localparam logic [THR_W-1:0] THR_RESET = 13'd100;
    localparam logic [CD_W-1:0]  CD_RESET  = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEAK_THRESHOLD,
        CFG_COOLDOWN_RELOAD
    } t_cfg_idx;

    typedef enum logic {
        OP_PUSH,
        OP_EVAL
    } t_op;

    typedef logic signed [ACCEL_W-1:0] t_accel;
    typedef logic [MAG_W-1:0]          t_mag;
    typedef logic [SUM_W-1:0]          t_axis_sum;
    typedef logic [APOS_W-1:0]         t_apos;
    typedef logic [MSUM_W-1:0]         t_msum;
    typedef logic [MPOS_W-1:0]         t_mpos;
    typedef logic [SQ_W-1:0]           t_sumsq;
    typedef logic [ROOT_W-1:0]         t_root;
    typedef logic [MA_W-1:0]           t_mul_a;
    typedef logic [MB_W-1:0]           t_mul_b;
    typedef logic [P_W-1:0]            t_prod;

    typedef struct packed {
        logic   en;
        t_accel x;
        t_accel y;
        t_accel z;
    } t_push;

endpackage

### src/ssd_in_if.sv
// ----------------------------------------------------------------------------
// ssd_in_if
// Input channel: push or evaluate requests with three axis samples.
// ----------------------------------------------------------------------------
interface ssd_in_if;
    logic            valid;
    logic            ready;
    logic            operation;
    ssd_pkg::t_accel accel_x;
    ssd_pkg::t_accel accel_y;
    ssd_pkg::t_accel accel_z;

    modport source (output valid, operation, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, operation, accel_x, accel_y, accel_z, output ready);
endinterface

### src/ssd_out_if.sv
// ----------------------------------------------------------------------------
// ssd_out_if
// Output channel: step flag, magnitude and baseline.
// ----------------------------------------------------------------------------
interface ssd_out_if;
    logic          valid;
    logic          ready;
    logic          step_detected;
    ssd_pkg::t_mag current_magnitude;
    ssd_pkg::t_mag baseline_magnitude;

    modport source (output valid, step_detected, current_magnitude, baseline_magnitude,
                    input ready);
    modport sink   (input valid, step_detected, current_magnitude, baseline_magnitude,
                    output ready);
endinterface

### src/ssd_axis_store.sv
// ----------------------------------------------------------------------------
// ssd_axis_store
// Three sliding windows of absolute axis values with running sums.
// ----------------------------------------------------------------------------
module ssd_axis_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssd_pkg::t_push     i_push,
    output ssd_pkg::t_axis_sum o_sums [ssd_pkg::AXES]
);

    ssd_pkg::t_mag      r_win [ssd_pkg::AXES][ssd_pkg::AXIS_WINDOW];
    ssd_pkg::t_axis_sum r_sum [ssd_pkg::AXES];
    ssd_pkg::t_apos     r_pos;
    ssd_pkg::t_apos     n_pos;
    ssd_pkg::t_mag      w_abs [ssd_pkg::AXES];

    function automatic ssd_pkg::t_mag abs13(input ssd_pkg::t_accel v);
        ssd_pkg::t_mag u;
        u = ssd_pkg::t_mag'(v);
        return u[ssd_pkg::MAG_W-1] ? (~u + 1'b1) : u;
    endfunction

    always_comb begin
        w_abs[0] = abs13(i_push.x);
        w_abs[1] = abs13(i_push.y);
        w_abs[2] = abs13(i_push.z);
        n_pos    = (r_pos == ssd_pkg::t_apos'(ssd_pkg::AXIS_WINDOW - 1)) ? '0 : r_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            for (int a = 0; a < ssd_pkg::AXES; a++) begin
                r_sum[a] <= '0;
                for (int i = 0; i < ssd_pkg::AXIS_WINDOW; i++) begin
                    r_win[a][i] <= '0;
                end
            end
        end else if (i_push.en) begin
            r_pos <= n_pos;
            for (int a = 0; a < ssd_pkg::AXES; a++) begin
                r_win[a][r_pos] <= w_abs[a];
                r_sum[a]        <= r_sum[a] - ssd_pkg::t_axis_sum'(r_win[a][r_pos])
                                   + ssd_pkg::t_axis_sum'(w_abs[a]);
            end
        end
    end

    assign o_sums = r_sum;

endmodule

### src/ssd_mul.sv
// ----------------------------------------------------------------------------
// ssd_mul
// Shared registered multiplier for reciprocal means and squares.
// ----------------------------------------------------------------------------
module ssd_mul (
    input  logic            i_clk,
    input  ssd_pkg::t_mul_a i_a,
    input  ssd_pkg::t_mul_b i_b,
    output ssd_pkg::t_prod  o_prod
);

    ssd_pkg::t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= ssd_pkg::t_prod'(i_a) * ssd_pkg::t_prod'(i_b);
    end

    assign o_prod = r_prod;

endmodule

### src/ssd_isqrt.sv
// ----------------------------------------------------------------------------
// ssd_isqrt
// Iterative floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module ssd_isqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ssd_pkg::t_sumsq i_radicand,
    output logic            o_done,
    output ssd_pkg::t_root  o_root
);

    localparam int RW = ssd_pkg::ROOT_W + 2;

    logic [RW-1:0]                 r_rem;
    ssd_pkg::t_root                r_root;
    ssd_pkg::t_sumsq               r_x;
    logic [ssd_pkg::RCNT_W-1:0]    r_cnt;
    logic                          r_done;
    logic [RW-1:0]                 w_rem_sh;
    logic [RW-1:0]                 w_trial;
    logic                          w_fit;

    always_comb begin
        w_rem_sh = {r_rem[RW-3:0], r_x[ssd_pkg::SQ_W-1 -: 2]};
        w_trial  = {r_root, 2'b01};
        w_fit    = (w_rem_sh >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_rem  <= '0;
                r_root <= '0;
                r_x    <= i_radicand;
                r_cnt  <= ssd_pkg::RCNT_W'(ssd_pkg::ROOT_W);
                r_done <= 1'b0;
            end else if (r_cnt != '0) begin
                r_rem  <= w_fit ? (w_rem_sh - w_trial) : w_rem_sh;
                r_root <= {r_root[ssd_pkg::ROOT_W-2:0], w_fit};
                r_x    <= {r_x[ssd_pkg::SQ_W-3:0], 2'b00};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == ssd_pkg::RCNT_W'(1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### src/step_spike_detector.sv
// ----------------------------------------------------------------------------
// step_spike_detector
// Step detector on the spike of averaged acceleration magnitude over baseline.
//
// Input channel i_in carries an operation and three signed axis samples; a
// push stores the absolute axis values, an evaluate computes the magnitude,
// the baseline and the step flag. Every input transaction gives exactly one
// output transaction on o_out (a push gives all-zero fields).
// A push's result is valid in the cycle after its acceptance.
// An evaluate uses the shared multiplier for the three axis means and
// squares, takes thirteen root steps in the square root unit, and then
// updates the magnitude window, forms its mean and makes the step
// decision before the next acceptance is possible.
// One transaction is in work at a time; i_in.ready is high only while idle
// and the output register is free or being emptied in the same cycle.
// If the receiver stalls, the finished result waits in the output register
// and the block holds the next evaluate before its final write.
// Configuration writes via i_cfg_we/i_cfg_idx/i_cfg_data are taken at once.
// Synchronous reset clears all windows and running sums, loads the register
// defaults and the cooldown counter, and empties the output register.
// ----------------------------------------------------------------------------
module step_spike_detector (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ssd_in_if.sink                         i_in,
    ssd_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  ssd_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [ssd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_SQ,
        S_ACC,
        S_SQRT_GO,
        S_SQRT,
        S_MAG,
        S_MDIV,
        S_MRES
    } t_state;

    t_state                         r_state, n_state;
    logic [ssd_pkg::AXIS_IDX_W-1:0] r_axis_idx, n_axis_idx;
    ssd_pkg::t_sumsq                r_sumsq, n_sumsq;
    ssd_pkg::t_mag                  r_mag, n_mag;
    ssd_pkg::t_msum                 r_msum, n_msum;
    ssd_pkg::t_mpos                 r_mpos, n_mpos;
    logic                           r_was_over, n_was_over;
    logic [ssd_pkg::CD_W-1:0]       r_cooldown, n_cooldown;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_step, n_out_step;
    ssd_pkg::t_mag                  r_out_mag, n_out_mag;
    ssd_pkg::t_mag                  r_out_base, n_out_base;
    logic [ssd_pkg::THR_W-1:0]      r_thr;
    logic [ssd_pkg::CD_W-1:0]       r_reload;
    ssd_pkg::t_mag                  r_mwin [ssd_pkg::MAG_WINDOW];

    ssd_pkg::t_push                 w_push;
    ssd_pkg::t_axis_sum             w_sums [ssd_pkg::AXES];
    ssd_pkg::t_axis_sum             w_sum_sel;
    ssd_pkg::t_mul_a                w_mul_a;
    ssd_pkg::t_mul_b                w_mul_b;
    ssd_pkg::t_prod                 w_prod;
    ssd_pkg::t_mag                  w_mean;
    ssd_pkg::t_mag                  w_base;
    ssd_pkg::t_root                 w_root;
    logic                           w_sqrt_start;
    logic                           w_sqrt_done;
    logic                           w_out_free;
    logic                           w_accept;
    logic                           w_over;
    logic [ssd_pkg::CD_W-1:0]       w_cd_dec;
    logic                           w_step;

    ssd_axis_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_sums  (w_sums)
    );

    ssd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    ssd_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (r_sumsq),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    // handshake and datapath selects
    always_comb begin
        w_out_free   = !r_out_valid || o_out.ready;
        i_in.ready   = (r_state == S_IDLE) && w_out_free;
        w_accept     = i_in.valid && i_in.ready;
        w_push.en    = w_accept && (i_in.operation == ssd_pkg::OP_PUSH);
        w_push.x     = i_in.accel_x;
        w_push.y     = i_in.accel_y;
        w_push.z     = i_in.accel_z;
        w_sqrt_start = (r_state == S_SQRT_GO);

        case (r_axis_idx)
            2'd0:    w_sum_sel = w_sums[0];
            2'd1:    w_sum_sel = w_sums[1];
            2'd2:    w_sum_sel = w_sums[2];
            default: w_sum_sel = '0;
        endcase

        w_mean = w_prod[ssd_pkg::K_A +: ssd_pkg::MAG_W];
        w_base = w_prod[ssd_pkg::K_M +: ssd_pkg::MAG_W];

        case (r_state)
            S_DIV: begin
                w_mul_a = ssd_pkg::t_mul_a'(w_sum_sel);
                w_mul_b = ssd_pkg::t_mul_b'(ssd_pkg::RECIP_A);
            end
            S_SQ: begin
                w_mul_a = ssd_pkg::t_mul_a'(w_mean);
                w_mul_b = ssd_pkg::t_mul_b'(w_mean);
            end
            S_MDIV: begin
                w_mul_a = ssd_pkg::t_mul_a'(r_msum);
                w_mul_b = ssd_pkg::t_mul_b'(ssd_pkg::RECIP_M);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase

        w_over   = {1'b0, r_mag} > ({1'b0, w_base} + {1'b0, r_thr});
        w_cd_dec = (r_cooldown != '0) ? r_cooldown - 1'b1 : r_cooldown;
        w_step   = w_over && !r_was_over && (w_cd_dec == '0);
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_axis_idx  = r_axis_idx;
        n_sumsq     = r_sumsq;
        n_mag       = r_mag;
        n_msum      = r_msum;
        n_mpos      = r_mpos;
        n_was_over  = r_was_over;
        n_cooldown  = r_cooldown;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_step  = r_out_step;
        n_out_mag   = r_out_mag;
        n_out_base  = r_out_base;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.operation == ssd_pkg::OP_PUSH) begin
                        n_out_valid = 1'b1;
                        n_out_step  = 1'b0;
                        n_out_mag   = '0;
                        n_out_base  = '0;
                    end else begin
                        n_state    = S_DIV;
                        n_axis_idx = '0;
                        n_sumsq    = '0;
                    end
                end
            end
            S_DIV: n_state = S_SQ;
            S_SQ:  n_state = S_ACC;
            S_ACC: begin
                n_sumsq = r_sumsq + w_prod[ssd_pkg::SQ_W-1:0];
                if (r_axis_idx == ssd_pkg::AXIS_IDX_W'(ssd_pkg::AXES - 1)) begin
                    n_state = S_SQRT_GO;
                end else begin
                    n_axis_idx = r_axis_idx + 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_SQRT_GO: n_state = S_SQRT;
            S_SQRT: begin
                if (w_sqrt_done) begin
                    n_mag   = ssd_pkg::t_mag'(w_root);
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                n_msum  = r_msum - ssd_pkg::t_msum'(r_mwin[r_mpos])
                          + ssd_pkg::t_msum'(r_mag);
                n_mpos  = (r_mpos == ssd_pkg::t_mpos'(ssd_pkg::MAG_WINDOW - 1)) ?
                          '0 : r_mpos + 1'b1;
                n_state = S_MDIV;
            end
            S_MDIV: n_state = S_MRES;
            S_MRES: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_step  = w_step;
                    n_out_mag   = r_mag;
                    n_out_base  = w_base;
                    n_was_over  = w_over;
                    n_cooldown  = w_step ? r_reload : w_cd_dec;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis_idx  <= '0;
            r_msum      <= '0;
            r_mpos      <= '0;
            r_was_over  <= 1'b0;
            r_cooldown  <= ssd_pkg::CD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis_idx  <= n_axis_idx;
            r_msum      <= n_msum;
            r_mpos      <= n_mpos;
            r_was_over  <= n_was_over;
            r_cooldown  <= n_cooldown;
            r_out_valid <= n_out_valid;
        end
        r_sumsq    <= n_sumsq;
        r_mag      <= n_mag;
        r_out_step <= n_out_step;
        r_out_mag  <= n_out_mag;
        r_out_base <= n_out_base;
    end

    // magnitude window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ssd_pkg::MAG_WINDOW; i++) begin
                r_mwin[i] <= '0;
            end
        end else if (r_state == S_MAG) begin
            r_mwin[r_mpos] <= r_mag;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= ssd_pkg::THR_RESET;
            r_reload <= ssd_pkg::CD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ssd_pkg::CFG_PEAK_THRESHOLD:  r_thr    <= i_cfg_data;
                ssd_pkg::CFG_COOLDOWN_RELOAD: r_reload <= i_cfg_data[ssd_pkg::CD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.step_detected      = r_out_step;
    assign o_out.current_magnitude  = r_out_mag;
    assign o_out.baseline_magnitude = r_out_base;

    a_step_above_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.step_detected |->
            o_out.current_magnitude > o_out.baseline_magnitude)
        else $error("step reported without magnitude above baseline");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE) || r_out_valid)
        else $error("accepted transaction neither in work nor delivered");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
            (o_out.current_magnitude <= ssd_pkg::t_mag'(ssd_pkg::MAG_MAX)) &&
            (o_out.baseline_magnitude <= ssd_pkg::t_mag'(ssd_pkg::MAG_MAX)))
        else $error("magnitude or baseline out of range");

endmodule

### tb/step_spike_detector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// step_spike_detector_tb
// Self-checking bench for the step spike detector. A behavioural predictor
// keeps its own copy of the axis and magnitude windows, edge flag and cooldown
// count, and works out the result of every accepted transaction. Results are
// checked field by field in order. Stimulus is a short directed part, then
// bursts of well-formed sample/evaluate sequences with random content mixed
// with noise, under several register settings, random idling on both
// channels, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module step_spike_detector_tb;

    localparam int CLK_PERIOD   = 4;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int IDLE_PERCENT = 6;
    localparam int PRINT_CAP    = 50;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 64;

    localparam ssd_pkg::t_accel AXIS_MIN = ssd_pkg::t_accel'(-4096);
    localparam ssd_pkg::t_accel AXIS_MAX = ssd_pkg::t_accel'(4095);

    typedef struct packed {
        logic          step;
        ssd_pkg::t_mag magnitude;
        ssd_pkg::t_mag baseline;
    } t_step_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    ssd_pkg::t_cfg_idx              cfg_idx;
    logic [ssd_pkg::CFG_DATA_W-1:0] cfg_data;

    ssd_in_if  in_ch ();
    ssd_out_if out_ch ();

    step_spike_detector uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predictor state
    ssd_pkg::t_mag             axis_hist [ssd_pkg::AXES][ssd_pkg::AXIS_WINDOW];
    int                        axis_pos;
    ssd_pkg::t_mag             mag_hist [ssd_pkg::MAG_WINDOW];
    int                        mag_pos;
    bit                        prev_over;
    logic [ssd_pkg::CD_W-1:0]  cooldown_left;
    logic [ssd_pkg::THR_W-1:0] threshold_reg;
    logic [ssd_pkg::CD_W-1:0]  reload_reg;

    t_step_result expected_results [$];
    int           error_count   = 0;
    int           cycle_count   = 0;
    int           hold_off_left = 0;
    bit           idle_on       = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic void reset_detector_model();
        for (int a = 0; a < ssd_pkg::AXES; a++) begin
            for (int i = 0; i < ssd_pkg::AXIS_WINDOW; i++) axis_hist[a][i] = '0;
        end
        for (int i = 0; i < ssd_pkg::MAG_WINDOW; i++) mag_hist[i] = '0;
        axis_pos      = 0;
        mag_pos       = 0;
        prev_over     = 1'b0;
        threshold_reg = ssd_pkg::THR_RESET;
        reload_reg    = ssd_pkg::CD_RESET;
        cooldown_left = ssd_pkg::CD_RESET;
    endfunction

    function automatic ssd_pkg::t_mag axis_abs(ssd_pkg::t_accel v);
        int s;
        s = v;
        return (s < 0) ? ssd_pkg::t_mag'(-s) : ssd_pkg::t_mag'(s);
    endfunction

    function automatic ssd_pkg::t_mag floor_sqrt(int unsigned n);
        ssd_pkg::t_mag root;
        longint        trial;
        root = '0;
        for (int b = ssd_pkg::MAG_W - 1; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= n) root = ssd_pkg::t_mag'(trial);
        end
        return root;
    endfunction

    function automatic t_step_result advance_detector(ssd_pkg::t_op op,
                                                      ssd_pkg::t_accel x,
                                                      ssd_pkg::t_accel y,
                                                      ssd_pkg::t_accel z);
        t_step_result res;
        int unsigned  sum;
        int unsigned  sumsq;
        int unsigned  mean;
        int           mag_i;
        int           base_i;
        int           thr_i;
        bit           over;
        bit           step;
        res = '0;
        if (op == ssd_pkg::OP_PUSH) begin
            axis_hist[0][axis_pos] = axis_abs(x);
            axis_hist[1][axis_pos] = axis_abs(y);
            axis_hist[2][axis_pos] = axis_abs(z);
            axis_pos = (axis_pos + 1) % ssd_pkg::AXIS_WINDOW;
            return res;
        end
        sumsq = 0;
        for (int a = 0; a < ssd_pkg::AXES; a++) begin
            sum = 0;
            for (int i = 0; i < ssd_pkg::AXIS_WINDOW; i++) sum += axis_hist[a][i];
            mean = sum / ssd_pkg::AXIS_WINDOW;
            sumsq += mean * mean;
        end
        res.magnitude = floor_sqrt(sumsq);
        mag_hist[mag_pos] = res.magnitude;
        mag_pos = (mag_pos + 1) % ssd_pkg::MAG_WINDOW;
        sum = 0;
        for (int i = 0; i < ssd_pkg::MAG_WINDOW; i++) sum += mag_hist[i];
        res.baseline = ssd_pkg::t_mag'(sum / ssd_pkg::MAG_WINDOW);
        mag_i  = res.magnitude;
        base_i = res.baseline;
        thr_i  = threshold_reg;
        over   = (mag_i - base_i) > thr_i;
        // cooldown counts down on every evaluate, edge flag always follows
        if (cooldown_left != 0) cooldown_left--;
        step = over && !prev_over && (cooldown_left == 0);
        if (step) cooldown_left = reload_reg;
        prev_over = over;
        res.step = step;
        return res;
    endfunction

    function automatic ssd_pkg::t_accel rand_axis(int lo, int hi);
        int v;
        v = $urandom_range(hi, lo);
        if (v >= 4096) return AXIS_MIN;
        return ($urandom_range(1) != 0) ? ssd_pkg::t_accel'(-v) : ssd_pkg::t_accel'(v);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("mismatch %0s: got %0d, expected %0d (cycle %0d)",
                     what, got, want, cycle_count);
    endtask

    task automatic send_item(ssd_pkg::t_op op, ssd_pkg::t_accel x, ssd_pkg::t_accel y,
                             ssd_pkg::t_accel z);
        @(negedge i_clk);
        if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.accel_x   <= x;
        in_ch.accel_y   <= y;
        in_ch.accel_z   <= z;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_results.push_back(advance_detector(op, x, y, z));
    endtask

    task automatic wait_until_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(ssd_pkg::t_cfg_idx idx,
                                  logic [ssd_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            ssd_pkg::CFG_PEAK_THRESHOLD:  threshold_reg = data[ssd_pkg::THR_W-1:0];
            ssd_pkg::CFG_COOLDOWN_RELOAD: reload_reg    = data[ssd_pkg::CD_W-1:0];
            default: ;
        endcase
    endtask

    // upper data bits above the reload width are random and must be dropped
    task automatic apply_settings(logic [ssd_pkg::THR_W-1:0] thr,
                                  logic [ssd_pkg::CD_W-1:0] reload);
        wait_until_drained();
        write_register(ssd_pkg::CFG_PEAK_THRESHOLD, thr);
        write_register(ssd_pkg::CFG_COOLDOWN_RELOAD,
                       {(ssd_pkg::CFG_DATA_W - ssd_pkg::CD_W)'($urandom), reload});
    endtask

    task automatic random_traffic(int n_items);
        int sent;
        int amp_lo;
        int amp_hi;
        int pushes;
        int evals;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 15) begin
                send_item(ssd_pkg::t_op'($urandom_range(1)), ssd_pkg::t_accel'($urandom),
                          ssd_pkg::t_accel'($urandom), ssd_pkg::t_accel'($urandom));
                sent++;
            end else begin
                case ($urandom_range(2))
                    0: begin
                        amp_lo = 0;
                        amp_hi = 150;
                    end
                    1: begin
                        amp_lo = 1500;
                        amp_hi = 4096;
                    end
                    default: begin
                        amp_lo = 0;
                        amp_hi = 4096;
                    end
                endcase
                pushes = $urandom_range(1, ssd_pkg::AXIS_WINDOW + 1);
                evals  = $urandom_range(1, 3);
                repeat (pushes)
                    send_item(ssd_pkg::OP_PUSH, rand_axis(amp_lo, amp_hi),
                              rand_axis(amp_lo, amp_hi), rand_axis(amp_lo, amp_hi));
                repeat (evals)
                    send_item(ssd_pkg::OP_EVAL, ssd_pkg::t_accel'($urandom),
                              ssd_pkg::t_accel'($urandom), ssd_pkg::t_accel'($urandom));
                sent += pushes + evals;
            end
        end
    endtask

    task automatic test_reset_state();
        send_item(ssd_pkg::OP_EVAL, '0, '0, '0);
        send_item(ssd_pkg::OP_PUSH, '0, '0, '0);
        // sample fields on an evaluate are ignored
        send_item(ssd_pkg::OP_EVAL, AXIS_MAX, AXIS_MIN, ssd_pkg::t_accel'(-1));
    endtask

    task automatic test_field_extremes();
        repeat (ssd_pkg::AXIS_WINDOW) send_item(ssd_pkg::OP_PUSH, AXIS_MIN, AXIS_MIN, AXIS_MIN);
        send_item(ssd_pkg::OP_EVAL, '0, '0, '0);
        send_item(ssd_pkg::OP_PUSH, AXIS_MAX, AXIS_MIN, ssd_pkg::t_accel'(-1));
        send_item(ssd_pkg::OP_PUSH, ssd_pkg::t_accel'(1), '0, ssd_pkg::t_accel'(-2048));
        send_item(ssd_pkg::OP_EVAL, '0, '0, '0);
    endtask

    task automatic test_zero_reload();
        apply_settings('0, '0);
        repeat (3) send_item(ssd_pkg::OP_PUSH, '0, '0, '0);
        send_item(ssd_pkg::OP_EVAL, '0, '0, '0);
        repeat (3) send_item(ssd_pkg::OP_PUSH, AXIS_MIN, AXIS_MAX, AXIS_MIN);
        send_item(ssd_pkg::OP_EVAL, '0, '0, '0);
        send_item(ssd_pkg::OP_EVAL, '0, '0, '0);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: apply_settings(13'd40, 8'd3);
                1: apply_settings('0, '0);
                2: apply_settings({ssd_pkg::THR_W{1'b1}}, {ssd_pkg::CD_W{1'b1}});
                3: apply_settings(ssd_pkg::THR_W'($urandom_range(400)),
                                  ssd_pkg::CD_W'($urandom_range(6)));
                default: apply_settings(13'd1, {ssd_pkg::CD_W{1'b1}});
            endcase
            random_traffic(200);
        end
    endtask

    task automatic test_steady_flow();
        apply_settings(ssd_pkg::THR_W'($urandom_range(300)),
                       ssd_pkg::CD_W'($urandom_range(4)));
        @(posedge i_clk);
        idle_on = 1'b0;
        random_traffic(400);
        idle_on = 1'b1;
    endtask

    task automatic test_output_stall();
        @(negedge i_clk);
        in_ch.valid   <= 1'b0;
        hold_off_left = HOLD_CYCLES;
        random_traffic(60);
    endtask

    task automatic test_drain_pause();
        random_traffic(40);
        wait_until_drained();
        random_traffic(40);
    endtask

    // receiving side
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_off_left--;
            end else begin
                out_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_step_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("transaction with nothing expected", 1, 0);
            end else begin
                want = expected_results.pop_front();
                if (out_ch.step_detected !== want.step)
                    report_mismatch("step_detected", out_ch.step_detected, want.step);
                if (out_ch.current_magnitude !== want.magnitude)
                    report_mismatch("current_magnitude", out_ch.current_magnitude,
                                    want.magnitude);
                if (out_ch.baseline_magnitude !== want.baseline)
                    report_mismatch("baseline_magnitude", out_ch.baseline_magnitude,
                                    want.baseline);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = ssd_pkg::CFG_PEAK_THRESHOLD;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.operation = ssd_pkg::OP_PUSH;
        in_ch.accel_x   = '0;
        in_ch.accel_y   = '0;
        in_ch.accel_z   = '0;
        reset_detector_model();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_field_extremes();
        test_zero_reload();
        test_random_settings();
        test_steady_flow();
        test_output_stall();
        test_drain_pause();

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
src/ssd_pkg.sv
src/ssd_in_if.sv
src/ssd_out_if.sv
src/ssd_axis_store.sv
src/ssd_mul.sv
src/ssd_isqrt.sv
src/step_spike_detector.sv
tb/step_spike_detector_tb.sv
